// File: sv/adm_pkg.sv
// package for the automatic door motor controller
// holds state types, drive codes, mode codes and field widths; no dependencies
`default_nettype none

package adm_pkg;

    localparam int unsigned TimerW  = 16;
    localparam int unsigned SampleW = 8;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDatW = 16;

    localparam logic [CfgIdxW-1:0] CFG_BLINK  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_HOLD   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_SAMPLE = 2'd2;

    localparam logic [1:0] DRV_STOP  = 2'd0;
    localparam logic [1:0] DRV_OPEN  = 2'd1;
    localparam logic [1:0] DRV_CLOSE = 2'd2;

    localparam logic [1:0] MODE_CODE_AUTO   = 2'd0;
    localparam logic [1:0] MODE_CODE_MANUAL = 2'd1;
    localparam logic [1:0] MODE_CODE_SEMI   = 2'd2;

    typedef enum logic [2:0] {
        MODE_AUTO   = 3'b001,
        MODE_MANUAL = 3'b010,
        MODE_SEMI   = 3'b100
    } t_mode;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_BLINK   = 6'b000010,
        PH_OPENING = 6'b000100,
        PH_HOLD    = 6'b001000,
        PH_CLOSING = 6'b010000,
        PH_REBLINK = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [TimerW-1:0]  blink_ticks;
        logic [TimerW-1:0]  hold_ticks;
        logic [SampleW-1:0] mode_sample_ticks;
    } t_cfg;

    typedef struct packed {
        logic motion_seen;
        logic open_button_n;
        logic mode_button_n;
        logic close_button_n;
        logic open_limit_n;
        logic close_limit_n;
    } t_pins;

    typedef struct packed {
        logic [1:0] motor_drive;
        logic       green_lamp;
        logic       red_lamp;
        logic [1:0] mode_now;
    } t_result;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        unique case (m)
            MODE_MANUAL: c = MODE_CODE_MANUAL;
            MODE_SEMI:   c = MODE_CODE_SEMI;
            default:     c = MODE_CODE_AUTO;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/adm_cfg_regs.sv
// configuration registers of the door controller
// depends on adm_pkg
`default_nettype none

module adm_cfg_regs
    import adm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic [CfgIdxW-1:0] i_cfg_index,
    input  wire logic [CfgDatW-1:0] i_cfg_data,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blink_ticks       <= TimerW'(200);
            r_cfg.hold_ticks        <= TimerW'(2000);
            r_cfg.mode_sample_ticks <= SampleW'(20);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BLINK:  r_cfg.blink_ticks       <= i_cfg_data[TimerW-1:0];
                CFG_HOLD:   r_cfg.hold_ticks        <= i_cfg_data[TimerW-1:0];
                CFG_SAMPLE: r_cfg.mode_sample_ticks <= i_cfg_data[SampleW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: sv/adm_core.sv
// door controller state and per-tick update logic
// depends on adm_pkg; state advances once per tick when i_step is high
`default_nettype none

module adm_core
    import adm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire t_cfg  i_cfg,
    input  wire t_pins i_pins,
    output t_result    o_result
);

    t_mode              r_mode, n_mode;
    logic               r_prev, n_prev;
    logic [SampleW-1:0] r_cnt, n_cnt;
    logic               r_open_l, n_open_l;
    logic               r_close_l, n_close_l;
    t_phase             r_phase, n_phase;
    logic [TimerW-1:0]  r_timer, n_timer;
    logic [1:0]         r_drv, n_drv;
    logic               r_green, n_green;
    logic               r_red, n_red;

    logic               frozen;
    logic               changed;
    logic [SampleW-1:0] period;
    logic [SampleW-1:0] cnt_inc;
    logic [TimerW-1:0]  timer_inc;
    logic               lim;

    always_comb begin
        n_mode    = r_mode;
        n_prev    = r_prev;
        n_cnt     = r_cnt;
        n_open_l  = r_open_l;
        n_close_l = r_close_l;
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_drv     = r_drv;
        n_green   = r_green;
        n_red     = r_red;
        changed   = 1'b0;
        lim       = 1'b0;
        timer_inc = r_timer + TimerW'(1);
        cnt_inc   = r_cnt + SampleW'(1);
        period    = (i_cfg.mode_sample_ticks == '0) ? SampleW'(1) : i_cfg.mode_sample_ticks;
        frozen    = (r_mode == MODE_AUTO) &&
                    (r_phase == PH_BLINK || r_phase == PH_REBLINK || r_phase == PH_HOLD);

        // mode button sample
        if (!frozen) begin
            n_cnt = cnt_inc;
            if (cnt_inc >= period) begin
                n_cnt = '0;
                if (!i_pins.mode_button_n && r_prev) begin
                    unique case (r_mode)
                        MODE_MANUAL: n_mode = MODE_SEMI;
                        MODE_SEMI:   n_mode = MODE_AUTO;
                        default:     n_mode = MODE_MANUAL;
                    endcase
                    n_open_l  = 1'b0;
                    n_close_l = 1'b0;
                    n_phase   = PH_IDLE;
                    n_timer   = '0;
                    n_drv     = DRV_STOP;
                    n_green   = 1'b0;
                    n_red     = 1'b0;
                    changed   = 1'b1;
                end
                n_prev = i_pins.mode_button_n;
            end
        end

        if (!changed) begin
            unique case (r_mode)
                MODE_MANUAL: begin
                    if (!i_pins.open_button_n || !i_pins.close_button_n) begin
                        lim = !i_pins.open_button_n ? i_pins.open_limit_n
                                                    : i_pins.close_limit_n;
                        if (!lim) begin
                            n_drv = DRV_STOP;
                            n_red = 1'b0;
                        end else begin
                            n_drv   = !i_pins.open_button_n ? DRV_OPEN : DRV_CLOSE;
                            n_green = 1'b0;
                            n_red   = 1'b1;
                        end
                    end else begin
                        n_drv   = DRV_STOP;
                        n_green = 1'b0;
                        n_red   = 1'b0;
                    end
                end
                MODE_SEMI: begin
                    if (!i_pins.open_button_n && !n_open_l && i_pins.open_limit_n) begin
                        n_open_l  = 1'b1;
                        n_close_l = 1'b0;
                        n_drv     = DRV_OPEN;
                        n_red     = 1'b1;
                    end
                    if (!i_pins.close_button_n && !n_close_l && i_pins.close_limit_n) begin
                        n_close_l = 1'b1;
                        n_open_l  = 1'b0;
                        n_drv     = DRV_CLOSE;
                        n_red     = 1'b1;
                    end
                    if (n_open_l && !i_pins.open_limit_n) begin
                        n_open_l = 1'b0;
                        n_drv    = DRV_STOP;
                        n_red    = 1'b0;
                    end
                    if (n_close_l && !i_pins.close_limit_n) begin
                        n_close_l = 1'b0;
                        n_drv     = DRV_STOP;
                        n_red     = 1'b0;
                    end
                    if (!n_open_l && !n_close_l) begin
                        n_green = 1'b0;
                        n_red   = 1'b0;
                    end
                end
                default: begin
                    unique case (r_phase)
                        PH_IDLE: begin
                            if (i_pins.motion_seen) begin
                                n_green = 1'b1;
                                n_phase = PH_BLINK;
                                n_timer = '0;
                            end
                        end
                        PH_BLINK: begin
                            n_timer = timer_inc;
                            if (timer_inc >= i_cfg.blink_ticks) begin
                                n_green = 1'b0;
                                n_red   = 1'b1;
                                n_timer = '0;
                                if (i_pins.open_limit_n) begin
                                    n_drv   = DRV_OPEN;
                                    n_phase = PH_OPENING;
                                end else begin
                                    n_phase = PH_HOLD;
                                end
                            end
                        end
                        PH_REBLINK: begin
                            n_timer = timer_inc;
                            if (timer_inc >= i_cfg.blink_ticks) begin
                                n_green = 1'b0;
                                n_timer = '0;
                                if (i_pins.open_limit_n) begin
                                    n_drv   = DRV_OPEN;
                                    n_phase = PH_OPENING;
                                end else begin
                                    n_drv   = DRV_STOP;
                                    n_red   = 1'b0;
                                    n_phase = PH_HOLD;
                                end
                            end
                        end
                        PH_OPENING: begin
                            if (!i_pins.open_limit_n) begin
                                n_drv   = DRV_STOP;
                                n_red   = 1'b0;
                                n_green = 1'b0;
                                n_phase = PH_HOLD;
                                n_timer = '0;
                            end
                        end
                        PH_HOLD: begin
                            n_timer = timer_inc;
                            if (timer_inc >= i_cfg.hold_ticks) begin
                                n_timer = '0;
                                if (i_pins.close_limit_n) begin
                                    n_red   = 1'b1;
                                    n_drv   = DRV_CLOSE;
                                    n_phase = PH_CLOSING;
                                end else begin
                                    n_green = 1'b0;
                                    n_phase = PH_IDLE;
                                end
                            end
                        end
                        PH_CLOSING: begin
                            if (!i_pins.close_limit_n) begin
                                n_drv   = DRV_STOP;
                                n_red   = 1'b0;
                                n_green = 1'b0;
                                n_phase = PH_IDLE;
                                n_timer = '0;
                            end else if (i_pins.motion_seen) begin
                                n_timer = '0;
                                if (i_pins.open_limit_n) begin
                                    n_green = 1'b1;
                                    n_phase = PH_REBLINK;
                                end else begin
                                    n_phase = PH_HOLD;
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_timer = '0;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_AUTO;
            r_prev    <= 1'b1;
            r_cnt     <= '0;
            r_open_l  <= 1'b0;
            r_close_l <= 1'b0;
            r_phase   <= PH_IDLE;
            r_timer   <= '0;
            r_drv     <= DRV_STOP;
            r_green   <= 1'b0;
            r_red     <= 1'b0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_prev    <= n_prev;
            r_cnt     <= n_cnt;
            r_open_l  <= n_open_l;
            r_close_l <= n_close_l;
            r_phase   <= n_phase;
            r_timer   <= n_timer;
            r_drv     <= n_drv;
            r_green   <= n_green;
            r_red     <= n_red;
        end
    end

    assign o_result.motor_drive = n_drv;
    assign o_result.green_lamp  = n_green;
    assign o_result.red_lamp    = n_red;
    assign o_result.mode_now    = mode_code(n_mode);

endmodule

`default_nettype wire

// File: sv/automatic_door_motor_controller.sv
// top level of the automatic door motor controller
// depends on adm_pkg, adm_cfg_regs and adm_core
//
// usage:
//   s_axis carries one millisecond tick per transaction; tdata bits from 0 up:
//   motion_seen, open_button_n, mode_button_n, close_button_n, open_limit_n,
//   close_limit_n, two unused bits
//   m_axis returns one result per tick; tdata bits from 0 up: motor_drive[1:0],
//   green_lamp, red_lamp, mode_now[1:0], two zero bits
//   the cfg channel writes blink_ticks (index 0), hold_ticks (1) and
//   mode_sample_ticks (2); o_cfg_ready is always high, other indexes are dropped
//   and writes are meant only while no tick is in flight
// flow: a tick lands in the input register, then the state update writes the
//   result register and the core state together; one tick per cycle is
//   sustained while m_axis_tready stays high
// stall: while m_axis_tready is low the result holds, the input register
//   keeps one more tick, then s_axis_tready drops
// reset: both stages empty, auto mode, motor stopped, lamps off, registers at
//   200, 2000 and 20 ticks
`default_nettype none

module automatic_door_motor_controller
    import adm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // motion, open_btn_n, mode_btn_n,
                                                    // close_btn_n, open_lim_n, close_lim_n
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [7:0]              m_axis_tdata,   // motor_drive[1:0], green, red, mode_now[1:0]
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CfgIdxW-1:0] i_cfg_index,
    input  wire logic [CfgDatW-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_pins   pins;
    t_result result;

    logic    r_in_valid;
    logic    [5:0] r_in_data;
    logic    r_out_valid;
    t_result r_out;
    logic    step;

    assign o_cfg_ready   = 1'b1;
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    adm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign pins.motion_seen    = r_in_data[0];
    assign pins.open_button_n  = r_in_data[1];
    assign pins.mode_button_n  = r_in_data[2];
    assign pins.close_button_n = r_in_data[3];
    assign pins.open_limit_n   = r_in_data[4];
    assign pins.close_limit_n  = r_in_data[5];

    adm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cfg    (cfg),
        .i_pins   (pins),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata[5:0];
        end
        if (step) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.mode_now, r_out.red_lamp, r_out.green_lamp,
                            r_out.motor_drive};

endmodule

`default_nettype wire

// File: bench/door_result_checker.sv
`timescale 1ns / 1ps
// watches the tick, result and register channels of the door controller,
// predicts each result from its own copy of the door state and compares it
// depends on adm_pkg for field widths, register indexes and state codes

module door_result_checker
    import adm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [7:0]         m_axis_tdata,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgDatW-1:0] i_cfg_data,
    output int                 o_pending,
    output int                 o_fail_count
);

    logic [TimerW-1:0]  blink_cfg;
    logic [TimerW-1:0]  hold_cfg;
    logic [SampleW-1:0] sample_cfg;

    t_mode              door_mode;
    logic               mode_btn_last;
    logic [SampleW-1:0] sample_cnt;
    logic               open_latch;
    logic               close_latch;
    t_phase             door_phase;
    logic [TimerW-1:0]  phase_cnt;
    logic [1:0]         drive;
    logic               green;
    logic               red;

    t_result door_outputs_due[$];
    int      fails = 0;

    function automatic void begin_phase(input t_phase ph);
        door_phase = ph;
        phase_cnt  = '0;
    endfunction

    function automatic logic phase_elapsed(input logic [TimerW-1:0] lim);
        phase_cnt = phase_cnt + 1'b1;
        return phase_cnt >= lim;
    endfunction

    task automatic predict_door_outputs(input t_pins p, output t_result r);
        logic               frozen;
        logic               changed;
        logic [SampleW-1:0] period;
        logic               lim;
        changed = 1'b0;
        frozen  = (door_mode == MODE_AUTO) &&
                  (door_phase == PH_BLINK || door_phase == PH_REBLINK ||
                   door_phase == PH_HOLD);

        // mode button sampling comes first in a tick
        if (!frozen) begin
            period     = (sample_cfg == '0) ? SampleW'(1) : sample_cfg;
            sample_cnt = sample_cnt + 1'b1;
            if (sample_cnt >= period) begin
                sample_cnt = '0;
                if (!p.mode_button_n && mode_btn_last) begin
                    case (door_mode)
                        MODE_MANUAL: door_mode = MODE_SEMI;
                        MODE_SEMI:   door_mode = MODE_AUTO;
                        default:     door_mode = MODE_MANUAL;
                    endcase
                    open_latch  = 1'b0;
                    close_latch = 1'b0;
                    begin_phase(PH_IDLE);
                    drive   = DRV_STOP;
                    green   = 1'b0;
                    red     = 1'b0;
                    changed = 1'b1;
                end
                mode_btn_last = p.mode_button_n;
            end
        end

        if (!changed) begin
            case (door_mode)
                MODE_MANUAL: begin
                    if (!p.open_button_n || !p.close_button_n) begin
                        lim = !p.open_button_n ? p.open_limit_n : p.close_limit_n;
                        if (!lim) begin
                            drive = DRV_STOP;
                            red   = 1'b0;
                        end else begin
                            drive = !p.open_button_n ? DRV_OPEN : DRV_CLOSE;
                            green = 1'b0;
                            red   = 1'b1;
                        end
                    end else begin
                        drive = DRV_STOP;
                        green = 1'b0;
                        red   = 1'b0;
                    end
                end
                MODE_SEMI: begin
                    if (!p.open_button_n && !open_latch && p.open_limit_n) begin
                        open_latch  = 1'b1;
                        close_latch = 1'b0;
                        drive       = DRV_OPEN;
                        red         = 1'b1;
                    end
                    // close is evaluated second so it wins a double press
                    if (!p.close_button_n && !close_latch && p.close_limit_n) begin
                        close_latch = 1'b1;
                        open_latch  = 1'b0;
                        drive       = DRV_CLOSE;
                        red         = 1'b1;
                    end
                    if (open_latch && !p.open_limit_n) begin
                        open_latch = 1'b0;
                        drive      = DRV_STOP;
                        red        = 1'b0;
                    end
                    if (close_latch && !p.close_limit_n) begin
                        close_latch = 1'b0;
                        drive       = DRV_STOP;
                        red         = 1'b0;
                    end
                    if (!open_latch && !close_latch) begin
                        green = 1'b0;
                        red   = 1'b0;
                    end
                end
                default: begin
                    case (door_phase)
                        PH_IDLE: begin
                            if (p.motion_seen) begin
                                green = 1'b1;
                                begin_phase(PH_BLINK);
                            end
                        end
                        PH_BLINK: begin
                            if (phase_elapsed(blink_cfg)) begin
                                green = 1'b0;
                                red   = 1'b1;
                                if (p.open_limit_n) begin
                                    drive = DRV_OPEN;
                                    begin_phase(PH_OPENING);
                                end else begin
                                    begin_phase(PH_HOLD);
                                end
                            end
                        end
                        PH_REBLINK: begin
                            if (phase_elapsed(blink_cfg)) begin
                                green = 1'b0;
                                if (p.open_limit_n) begin
                                    drive = DRV_OPEN;
                                    begin_phase(PH_OPENING);
                                end else begin
                                    drive = DRV_STOP;
                                    red   = 1'b0;
                                    begin_phase(PH_HOLD);
                                end
                            end
                        end
                        PH_OPENING: begin
                            if (!p.open_limit_n) begin
                                drive = DRV_STOP;
                                red   = 1'b0;
                                green = 1'b0;
                                begin_phase(PH_HOLD);
                            end
                        end
                        PH_HOLD: begin
                            if (phase_elapsed(hold_cfg)) begin
                                if (p.close_limit_n) begin
                                    red   = 1'b1;
                                    drive = DRV_CLOSE;
                                    begin_phase(PH_CLOSING);
                                end else begin
                                    green = 1'b0;
                                    begin_phase(PH_IDLE);
                                end
                            end
                        end
                        PH_CLOSING: begin
                            if (!p.close_limit_n) begin
                                drive = DRV_STOP;
                                red   = 1'b0;
                                green = 1'b0;
                                begin_phase(PH_IDLE);
                            end else if (p.motion_seen) begin
                                if (p.open_limit_n) begin
                                    green = 1'b1;
                                    begin_phase(PH_REBLINK);
                                end else begin
                                    begin_phase(PH_HOLD);
                                end
                            end
                        end
                        default: begin_phase(PH_IDLE);
                    endcase
                end
            endcase
        end

        r.motor_drive = drive;
        r.green_lamp  = green;
        r.red_lamp    = red;
        case (door_mode)
            MODE_MANUAL: r.mode_now = MODE_CODE_MANUAL;
            MODE_SEMI:   r.mode_now = MODE_CODE_SEMI;
            default:     r.mode_now = MODE_CODE_AUTO;
        endcase
    endtask

    task automatic check_field(input string fname, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pins   pins;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            blink_cfg     = 16'd200;
            hold_cfg      = 16'd2000;
            sample_cfg    = 8'd20;
            door_mode     = MODE_AUTO;
            mode_btn_last = 1'b1;
            sample_cnt    = '0;
            open_latch    = 1'b0;
            close_latch   = 1'b0;
            begin_phase(PH_IDLE);
            drive         = DRV_STOP;
            green         = 1'b0;
            red           = 1'b0;
            door_outputs_due.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BLINK:  blink_cfg  = i_cfg_data;
                    CFG_HOLD:   hold_cfg   = i_cfg_data;
                    CFG_SAMPLE: sample_cfg = i_cfg_data[SampleW-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pins.motion_seen    = s_axis_tdata[0];
                pins.open_button_n  = s_axis_tdata[1];
                pins.mode_button_n  = s_axis_tdata[2];
                pins.close_button_n = s_axis_tdata[3];
                pins.open_limit_n   = s_axis_tdata[4];
                pins.close_limit_n  = s_axis_tdata[5];
                predict_door_outputs(pins, want);
                door_outputs_due.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.motor_drive = m_axis_tdata[1:0];
                got.green_lamp  = m_axis_tdata[2];
                got.red_lamp    = m_axis_tdata[3];
                got.mode_now    = m_axis_tdata[5:4];
                if (door_outputs_due.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, m_axis_tdata);
                    fails++;
                end else begin
                    want = door_outputs_due.pop_front();
                    check_field("motor_drive", want.motor_drive, got.motor_drive);
                    check_field("green_lamp", want.green_lamp, got.green_lamp);
                    check_field("red_lamp", want.red_lamp, got.red_lamp);
                    check_field("mode_now", want.mode_now, got.mode_now);
                end
            end
        end
        o_pending    <= door_outputs_due.size();
        o_fail_count <= fails;
    end

endmodule

// File: bench/automatic_door_motor_controller_tb.sv
`timescale 1ns / 1ps
// top of the door controller bench: clock, reset, tick and register stimulus
// depends on adm_pkg, automatic_door_motor_controller and door_result_checker

module automatic_door_motor_controller_tb;
    import adm_pkg::*;

    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index   = '0;
    logic [CfgDatW-1:0] i_cfg_data    = '0;

    int fail_count;
    int pending;

    bit sender_gaps    = 1'b1;
    bit recv_gaps      = 1'b1;
    int stall_requests = 0;
    int stall_seen     = 0;
    int stall_left     = 0;

    // slowly changing pin levels for the structured random ticks
    logic open_pin  = 1'b1;
    logic mode_pin  = 1'b1;
    logic close_pin = 1'b1;
    logic olim_pin  = 1'b1;
    logic clim_pin  = 1'b1;

    automatic_door_motor_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    door_result_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stalls plus long hold-offs on request
    always @(posedge i_clk) begin
        if (stall_seen != stall_requests) begin
            stall_seen = stall_requests;
            stall_left = 80;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(recv_gaps && $urandom_range(99) < 7);
        end
    end

    function automatic logic [5:0] pack_tick(input logic motion, input logic open_b,
                                             input logic mode_b, input logic close_b,
                                             input logic open_l, input logic close_l);
        return {close_l, open_l, close_b, mode_b, open_b, motion};
    endfunction

    task automatic send_tick(input logic [5:0] pins);
        if (sender_gaps && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, pins};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic load_timing(input logic [15:0] blink, input logic [15:0] hold,
                               input logic [15:0] sample_word);
        logic [CfgIdxW-1:0] idx [4];
        logic [CfgDatW-1:0] val [4];
        idx = '{CFG_BLINK, CFG_HOLD, CFG_SAMPLE, CFG_UNUSED};
        val = '{blink, hold, sample_word, 16'($urandom)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short timings and a zero sample interval so every tick not frozen samples the mode button
        load_timing(16'd1, 16'd1, 16'd0);

        // auto: blink ending at the open limit, motion while closing at the open limit
        send_tick(pack_tick(1, 1, 1, 1, 1, 1));
        send_tick(pack_tick(0, 1, 0, 1, 0, 1));
        send_tick(pack_tick(0, 1, 1, 1, 0, 1));
        send_tick(pack_tick(1, 1, 1, 1, 0, 1));
        send_tick(pack_tick(0, 1, 1, 1, 1, 0));
        // auto: full open, hold, close, then re-blink while closing
        send_tick(pack_tick(1, 1, 1, 1, 1, 1));
        send_tick(pack_tick(0, 1, 1, 1, 1, 1));
        send_tick(pack_tick(0, 1, 1, 1, 0, 1));
        send_tick(pack_tick(0, 1, 1, 1, 1, 1));
        send_tick(pack_tick(1, 1, 1, 1, 1, 1));
        send_tick(pack_tick(0, 1, 1, 1, 1, 1));
        // manual: drive, stop at a limit, both buttons
        send_tick(pack_tick(0, 1, 0, 1, 1, 1));
        send_tick(pack_tick(0, 0, 1, 1, 1, 1));
        send_tick(pack_tick(0, 0, 1, 1, 0, 1));
        send_tick(pack_tick(0, 0, 1, 0, 1, 0));
        send_tick(pack_tick(0, 1, 1, 0, 1, 0));
        // semi-auto: latches, later command clears the other, close wins a double press while closing
        send_tick(pack_tick(0, 1, 0, 1, 1, 1));
        send_tick(pack_tick(0, 0, 1, 1, 1, 1));
        send_tick(pack_tick(0, 1, 1, 0, 1, 1));
        send_tick(pack_tick(0, 0, 1, 0, 1, 1));
        send_tick(pack_tick(0, 1, 1, 1, 1, 0));
        // back to auto, then all-low and all-high pins
        send_tick(pack_tick(0, 1, 0, 1, 1, 1));
        send_tick(pack_tick(0, 0, 0, 0, 0, 0));
        send_tick(pack_tick(1, 1, 1, 1, 1, 1));
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: load_timing(16'd0, 16'd0, 16'd1);
                1: load_timing(16'($urandom_range(20)), 16'($urandom_range(40)), 16'd0);
                2: load_timing(16'($urandom_range(1, 10)), 16'($urandom_range(1, 20)),
                               {8'($urandom), 8'($urandom_range(2, 6))});
                4: load_timing(16'd5, 16'd5, 16'd3);
                default: load_timing(16'($urandom_range(30)), 16'($urandom_range(60)),
                                     16'($urandom_range(8)));
            endcase
            for (int n = 0; n < 245; n++) begin
                // long result hold-off while ticks keep coming
                if (ph == 2 && n == 120)
                    stall_requests++;
                if ($urandom_range(99) < 15) begin
                    send_tick(6'($urandom));
                end else begin
                    if ($urandom_range(99) < 8) open_pin = !open_pin;
                    if ($urandom_range(99) < 8) close_pin = !close_pin;
                    if ($urandom_range(99) < 3) mode_pin = !mode_pin;
                    if ($urandom_range(99) < 10) olim_pin = !olim_pin;
                    if ($urandom_range(99) < 10) clim_pin = !clim_pin;
                    send_tick(pack_tick($urandom_range(99) < 10, open_pin, mode_pin,
                                        close_pin, olim_pin, clim_pin));
                end
            end
            wait_drained();
        end

        // longest timings, no idling on either side
        sender_gaps = 1'b0;
        recv_gaps   = 1'b0;
        load_timing(16'hFFFF, 16'hFFFF, 16'd255);
        repeat (100) send_tick(6'($urandom));
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
